>>> hdl/bsad_pkg.sv
// Shared types, codes and decode functions for the bank-switched address decoder.
package bsad_pkg;

   localparam logic [2:0] KIND_CODE_READ = 3'd0;
   localparam logic [2:0] KIND_DATA_READ = 3'd1;
   localparam logic [2:0] KIND_WRITE     = 3'd2;
   localparam logic [2:0] KIND_JUMP      = 3'd3;
   localparam logic [2:0] KIND_INIT_BANK = 3'd4;

   localparam logic [2:0] TGT_NONE  = 3'd0;
   localparam logic [2:0] TGT_RAM   = 3'd1;
   localparam logic [2:0] TGT_ROM   = 3'd2;
   localparam logic [2:0] TGT_TIMER = 3'd3;
   localparam logic [2:0] TGT_SND1  = 3'd4;
   localparam logic [2:0] TGT_SND2  = 3'd5;
   localparam logic [2:0] TGT_XSND  = 3'd6;
   localparam logic [2:0] TGT_BANK  = 3'd7;

   localparam logic [1:0] ENV_RAM_ONLY    = 2'd0;
   localparam logic [1:0] ENV_TRANSPARENT = 2'd1;
   localparam logic [1:0] ENV_BANKED      = 2'd2;
   localparam logic [1:0] ENV_REAL        = 2'd3;

   localparam logic CSR_ENV_MODE    = 1'b0;
   localparam logic CSR_SECOND_CHIP = 1'b1;

   localparam logic [15:0] MIRROR_MASK   = 16'hfc1f;
   localparam logic [15:0] SND_BASE      = 16'hd400;
   localparam logic [7:0]  SND_PAGE      = 8'hd4;
   localparam logic [7:0]  SND2_PAGE     = 8'hd5;
   localparam logic [7:0]  TIMER_PAGE    = 8'hdc;
   localparam logic [7:0]  XSND_OFFSET   = 8'h1d;
   localparam logic [15:0] TIMER_LO_ADDR = 16'hdc04;
   localparam logic [15:0] TIMER_HI_ADDR = 16'hdc05;
   localparam logic [15:0] BANK_ADDR     = 16'h0001;
   localparam logic [15:0] BASIC_BASE    = 16'ha000;
   localparam logic [15:0] IO_BASE       = 16'hd000;
   localparam logic [15:0] KERNAL_BASE   = 16'he000;

   localparam logic [7:0] BANK_RESET    = 8'd7;
   localparam logic [7:0] BANK_ALL_ROM  = 8'd7;
   localparam logic [7:0] BANK_NO_BASIC = 8'd6;
   localparam logic [7:0] BANK_KERNAL   = 8'd5;
   localparam logic [7:0] BANK_IO_ONLY  = 8'd4;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] address;
      logic [7:0]  write_value;
      logic        use_cache;
   } req_type;

   typedef struct packed {
      logic [2:0]  target;
      logic        is_write;
      logic [15:0] device_address;
      logic [7:0]  out_data;
      logic        shadow_write;
      logic [15:0] shadow_address;
      logic        jump_allowed;
   } rsp_type;

   typedef struct packed {
      logic [1:0] env_mode;
      logic       second_chip;
   } cfg_type;

   function automatic logic basic_on(input logic [7:0] bank);
      return bank[1:0] == 2'b11;
   endfunction

   function automatic logic io_on(input logic [7:0] bank);
      return bank[2:0] > 3'd4;
   endfunction

   function automatic logic kernal_on(input logic [7:0] bank);
      return bank[1];
   endfunction

   function automatic logic [2:0] rom_target(input cfg_type cfg);
      return (cfg.env_mode == ENV_RAM_ONLY) ? TGT_RAM : TGT_ROM;
   endfunction

   function automatic rsp_type io_read(input cfg_type cfg, input logic [15:0] a,
                                       input logic cache);
      rsp_type     r;
      logic [15:0] f;
      r = '0;
      f = a & MIRROR_MASK;
      if (f[15:8] != SND_PAGE) begin
         if (a == TIMER_LO_ADDR || a == TIMER_HI_ADDR) begin
            r.target = TGT_TIMER;
            r.device_address = {8'h00, a[7:0]};
         end else begin
            r.target = rom_target(cfg);
            r.device_address = a;
         end
      end else if (f[7:0] >= XSND_OFFSET) begin
         r.target = TGT_XSND;
         r.device_address = a;
      end else if (cfg.second_chip && a[15:8] == SND2_PAGE) begin
         if (cache) begin
            r.target = rom_target(cfg);
            r.device_address = a;
         end else begin
            r.target = TGT_SND2;
            r.device_address = {8'h00, a[7:0]};
         end
      end else begin
         if (cache) begin
            r.target = rom_target(cfg);
            r.device_address = f;
         end else begin
            r.target = TGT_SND1;
            r.device_address = {8'h00, f[7:0]};
         end
      end
      return r;
   endfunction

   function automatic rsp_type banked_read(input cfg_type cfg, input logic [7:0] bank,
                                           input logic [15:0] a, input logic cache);
      rsp_type r;
      r = '0;
      r.target = TGT_RAM;
      r.device_address = a;
      if (a < BASIC_BASE) begin
         if (a == BANK_ADDR) begin
            r.target = TGT_BANK;
            r.out_data = bank;
         end
      end else if (a[15:12] == 4'ha || a[15:12] == 4'hb) begin
         if (basic_on(bank)) r.target = rom_target(cfg);
      end else if (a[15:12] == 4'hd) begin
         if (io_on(bank)) r = io_read(cfg, a, cache);
      end else if (a[15:12] != 4'hc) begin
         if (kernal_on(bank)) r.target = rom_target(cfg);
      end
      return r;
   endfunction

   function automatic rsp_type io_write(input cfg_type cfg, input logic [15:0] a,
                                        input logic [7:0] v, input logic cache);
      rsp_type     r;
      logic [15:0] f;
      r = '0;
      f = a & MIRROR_MASK;
      r.is_write = 1'b1;
      r.out_data = v;
      r.device_address = a;
      r.target = TGT_RAM;
      if (a == BANK_ADDR) begin
         r.target = TGT_BANK;
      end else if (a[15:8] == TIMER_PAGE) begin
         r.target = TGT_TIMER;
         r.device_address = {12'h000, a[3:0]};
      end else if (f[15:8] != SND_PAGE) begin
         r.target = TGT_RAM;
      end else if (f[7:0] >= XSND_OFFSET) begin
         r.target = TGT_XSND;
         r.device_address = a - SND_BASE;
      end else if (cfg.second_chip && a[15:8] == SND2_PAGE) begin
         r.target = TGT_SND2;
         r.device_address = {8'h00, a[7:0]};
         r.shadow_write = cache;
         r.shadow_address = cache ? a : 16'h0000;
      end else begin
         r.target = TGT_SND1;
         r.device_address = {8'h00, f[7:0]};
         r.shadow_write = cache;
         r.shadow_address = cache ? f : 16'h0000;
      end
      return r;
   endfunction

endpackage

>>> hdl/bsad_if.sv
// Channel interfaces for requests, results and register writes.
interface bsad_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] address;
   logic [7:0]  write_value;
   logic        use_cache;

   modport source (output valid, kind, address, write_value, use_cache, input ready);
   modport sink (input valid, kind, address, write_value, use_cache, output ready);
endinterface

interface bsad_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  target;
   logic        is_write;
   logic [15:0] device_address;
   logic [7:0]  out_data;
   logic        shadow_write;
   logic [15:0] shadow_address;
   logic        jump_allowed;

   modport source (output valid, target, is_write, device_address, out_data,
                   shadow_write, shadow_address, jump_allowed, input ready);
   modport sink (input valid, target, is_write, device_address, out_data,
                 shadow_write, shadow_address, jump_allowed, output ready);
endinterface

interface bsad_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/bsad_csr.sv
// Configuration registers: environment mode and second sound chip enable.
module bsad_csr
   import bsad_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   bsad_csr_if.sink     csr_ch,
   output cfg_type      cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_ENV_MODE:    cfg_in.env_mode = csr_ch.data[1:0];
            CSR_SECOND_CHIP: cfg_in.second_chip = csr_ch.data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.env_mode <= ENV_BANKED;
         cfg_ff.second_chip <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/bsad_decode.sv
// Single-pass decode of one transaction against the memory map and bank byte.
module bsad_decode
   import bsad_pkg::*;
(
   input  req_type     item,
   input  cfg_type     cfg,
   input  logic [7:0]  bank_byte,
   output rsp_type     result,
   output logic        bank_we,
   output logic [7:0]  bank_new
);

   logic [15:0] a;
   logic        jump_ok;
   logic [7:0]  init_bank;

   assign a = item.address;

   always_comb begin
      if (cfg.env_mode == ENV_BANKED && a >= BASIC_BASE) begin
         if (a[15:12] == 4'ha || a[15:12] == 4'hb) jump_ok = !basic_on(bank_byte);
         else if (a[15:12] == 4'hc)                jump_ok = 1'b1;
         else if (a[15:12] == 4'hd)                jump_ok = !io_on(bank_byte);
         else                                      jump_ok = !kernal_on(bank_byte);
      end else if (cfg.env_mode == ENV_TRANSPARENT && a >= IO_BASE
                   && kernal_on(bank_byte)) begin
         jump_ok = 1'b0;
      end else begin
         jump_ok = 1'b1;
      end
   end

   always_comb begin
      priority if (cfg.env_mode == ENV_RAM_ONLY) init_bank = BANK_IO_ONLY;
      else if (a < BASIC_BASE)                   init_bank = BANK_ALL_ROM;
      else if (a < IO_BASE)                      init_bank = BANK_NO_BASIC;
      else if (a >= KERNAL_BASE)                 init_bank = BANK_KERNAL;
      else                                       init_bank = BANK_IO_ONLY;
   end

   always_comb begin
      result = '0;
      bank_we = 1'b0;
      bank_new = item.write_value;
      unique case (item.kind)
         KIND_CODE_READ: begin
            if (cfg.env_mode == ENV_REAL) begin
               result = banked_read(cfg, bank_byte, a, item.use_cache);
            end else begin
               result.target = TGT_RAM;
               result.device_address = a;
            end
         end
         KIND_DATA_READ: begin
            if (cfg.env_mode == ENV_RAM_ONLY) begin
               result = io_read(cfg, a, item.use_cache);
            end else if (cfg.env_mode == ENV_TRANSPARENT) begin
               if (a[15:12] == 4'hd && io_on(bank_byte)) begin
                  result = io_read(cfg, a, item.use_cache);
               end else begin
                  result.target = TGT_RAM;
                  result.device_address = a;
               end
            end else begin
               result = banked_read(cfg, bank_byte, a, item.use_cache);
            end
         end
         KIND_WRITE: begin
            if (cfg.env_mode == ENV_RAM_ONLY
                || (a[15:12] == 4'hd && io_on(bank_byte))) begin
               result = io_write(cfg, a, item.write_value, item.use_cache);
            end else begin
               result.target = (a == BANK_ADDR) ? TGT_BANK : TGT_RAM;
               result.is_write = 1'b1;
               result.device_address = a;
               result.out_data = item.write_value;
            end
            bank_we = (result.target == TGT_BANK);
         end
         KIND_JUMP: begin
            result.device_address = a;
            result.jump_allowed = jump_ok;
         end
         KIND_INIT_BANK: begin
            result.target = TGT_RAM;
            result.is_write = 1'b1;
            result.device_address = BANK_ADDR;
            result.out_data = init_bank;
            bank_we = 1'b1;
            bank_new = init_bank;
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

>>> hdl/bank_switched_address_decoder.sv
// Top level: request register, decode stage, bank byte and result register.
// One transaction is accepted per clock while the request register is empty or the result
// register advances. Its result loads into the result register when that advances and stays
// offered until taken, so throughput is one transaction per cycle while results are taken. The
// request register feeds a single decode stage that reads and updates the bank byte in the same
// cycle the result register loads, so a write to address 1 or an init-bank request is seen by
// the very next transaction. A held result stalls the result register and, when full, the
// request register; a new request is still taken while the result register advances.
module bank_switched_address_decoder
   import bsad_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   bsad_req_if.sink  req_ch,
   bsad_rsp_if.source rsp_ch,
   bsad_csr_if.sink  csr_ch
);

   cfg_type     cfg;
   req_type     item_ff;
   req_type     item_in;
   logic        item_valid_ff;
   logic        item_valid_in;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [7:0]  bank_byte_ff;
   logic [7:0]  bank_byte_in;
   rsp_type     dec_result;
   logic        dec_bank_we;
   logic [7:0]  dec_bank_new;
   logic        advance;
   logic        take;

   bsad_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   bsad_decode u_decode (
      .item      (item_ff),
      .cfg       (cfg),
      .bank_byte (bank_byte_ff),
      .result    (dec_result),
      .bank_we   (dec_bank_we),
      .bank_new  (dec_bank_new)
   );

   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !item_valid_ff || advance;
   assign take = req_ch.valid && req_ch.ready;

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in = item_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      bank_byte_in = bank_byte_ff;
      if (advance) begin
         rsp_valid_in = item_valid_ff;
         item_valid_in = 1'b0;
         if (item_valid_ff) begin
            rsp_in = dec_result;
            if (dec_bank_we) bank_byte_in = dec_bank_new;
         end
      end
      if (take) begin
         item_valid_in = 1'b1;
         item_in.kind = req_ch.kind;
         item_in.address = req_ch.address;
         item_in.write_value = req_ch.write_value;
         item_in.use_cache = req_ch.use_cache;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bank_byte_ff <= BANK_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         bank_byte_ff <= bank_byte_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.target = rsp_ff.target;
   assign rsp_ch.is_write = rsp_ff.is_write;
   assign rsp_ch.device_address = rsp_ff.device_address;
   assign rsp_ch.out_data = rsp_ff.out_data;
   assign rsp_ch.shadow_write = rsp_ff.shadow_write;
   assign rsp_ch.shadow_address = rsp_ff.shadow_address;
   assign rsp_ch.jump_allowed = rsp_ff.jump_allowed;

   a_bank_hold: assert property (@(posedge clock) disable iff (reset)
      !(advance && item_valid_ff) |=> $stable(bank_byte_ff))
      else $error("bank byte changed without a decoded transaction");

   a_bank_follows_result: assert property (@(posedge clock) disable iff (reset)
      (advance && item_valid_ff && dec_bank_we) |=> (bank_byte_ff == rsp_ff.out_data))
      else $error("bank byte does not match the reported bank write");

   a_jump_no_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.jump_allowed) |-> (rsp_ff.target == TGT_NONE))
      else $error("jump result carries a target");

   a_shadow_sound_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.shadow_write) |->
         (rsp_ff.is_write && (rsp_ff.target == TGT_SND1 || rsp_ff.target == TGT_SND2)))
      else $error("shadow write outside a sound register write");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (item_valid_ff && rsp_valid_ff))
      else $error("request refused with room in the pipeline");

endmodule
